/* rtl/acclv_pkg.sv */
// package for the acceleration-limited velocity step
// holds the sequencer state type, register indexes and arithmetic constants
// no dependencies
`default_nettype none

package acclv_pkg;

  // fixed-point format
  localparam int unsigned QShift = 16;

  // shared restoring divider: 49-bit dividend, 31-bit divisor
  localparam int unsigned DivNumW  = 49;
  localparam int unsigned DivDenW  = 31;
  localparam int unsigned DivSteps = DivNumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // configuration register map
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_ACCEL     = 2'd0,
    REG_MAX_VELOCITY  = 2'd1,
    REG_DEAD_DISTANCE = 2'd2,
    REG_TICK_TIME     = 2'd3
  } cfg_reg_e;

  localparam logic [30:0] MaxAccelRst     = 31'd65536;
  localparam logic [30:0] MaxVelocityRst  = 31'd655360;
  localparam logic [30:0] DeadDistanceRst = 31'd0;
  localparam logic [16:0] TickTimeRst     = 17'd1092;

  localparam logic [30:0] U31Max = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_REM,
    ST_DIV,
    ST_DIV_END,
    ST_MUL_STOP,
    ST_CMP,
    ST_CMD,
    ST_MUL_LIM,
    ST_CLAMP,
    ST_DONE
  } state_e;

  // which quotient the shared divider is producing
  typedef enum logic {
    DIV_TTF,
    DIV_SPEED
  } div_sel_e;

endpackage

`default_nettype wire

/* rtl/accel_limited_velocity_step_top.sv */
// top level of the acceleration-limited velocity step, single module
// depends on acclv_pkg for state type, register map and constants
`default_nettype none

// One-axis motion update in signed Q16.16. Each input beat carries a target
// velocity, the measured position and the target position; the block keeps
// the current velocity internally (zero after reset) and returns one beat with
// the updated velocity and the distance left beyond the dead zone. The command
// is the target velocity, or the target velocity plus or minus (toward the
// target position) a capped approach speed when the stopping distance still
// fits in the distance left; the kept velocity then moves toward it by at most
// max_accel * tick_time. The sequencer divides for the time to final velocity
// on a single restoring divider (one quotient bit per cycle), forms the
// stopping distance on a shared 32x32 multiplier and compares it; only when it
// fits in the distance left does the same divider produce the approach speed.
// Both paths end with the limit product, the clamp and the output load.
// in_ready_o is high only while the sequencer is idle; a finished result
// sits in the output register, so the next beat is taken while it waits.
// Configuration writes are registered and should be issued only when idle.
// A max_accel or tick_time of zero acts as one.

module accel_limited_velocity_step_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // configuration write port
  input  wire                           cfg_we_i,
  input  wire  [acclv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire  [acclv_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  signed [31:0]            target_velocity_i,
  input  wire  signed [31:0]            current_position_i,
  input  wire  signed [31:0]            target_position_i,
  // output channel
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [31:0]            new_velocity_o,
  output logic        [30:0]            remaining_distance_o
);
  import acclv_pkg::*;

  // saturate a 34-bit signed value to 32 bits
  function automatic logic [31:0] sat_s32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [30:0] max_accel_q, max_velocity_q, dead_distance_q;
  logic [16:0] tick_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_accel_q     <= MaxAccelRst;
      max_velocity_q  <= MaxVelocityRst;
      dead_distance_q <= DeadDistanceRst;
      tick_time_q     <= TickTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MAX_ACCEL:     max_accel_q     <= cfg_data_i;
        REG_MAX_VELOCITY:  max_velocity_q  <= cfg_data_i;
        REG_DEAD_DISTANCE: dead_distance_q <= cfg_data_i;
        REG_TICK_TIME:     tick_time_q     <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // zero acts as the smallest step
  logic [30:0] accel_eff;
  logic [16:0] dt_eff;
  assign accel_eff = (max_accel_q == '0) ? 31'd1 : max_accel_q;
  assign dt_eff    = (tick_time_q == '0) ? 17'd1 : tick_time_q;

  // ---------------------------------------------------------------------------
  // sequencer state and control registers
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  div_sel_e            div_sel_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                out_valid_q;
  logic signed [31:0]  vel_q;        // kept velocity

  // payload registers
  logic signed [31:0]  tv_q, cp_q, tp_q;
  logic [32:0]         adp_q;        // |delta position|
  logic                dp_pos_q, dp_neg_q;
  logic [32:0]         adv_q;        // |target velocity - kept velocity|
  logic [30:0]         rem_q;        // distance beyond dead zone
  logic [DivNumW-1:0]  num_q;        // dividend, shifted out msb first
  logic [DivNumW-1:0]  quo_q;
  logic [DivDenW-1:0]  rmd_q;
  logic [DivDenW-1:0]  dvsr_q;
  logic [30:0]         ttf_q;        // time to final velocity
  logic [30:0]         spd_q;        // approach speed
  logic [63:0]         prod_q;       // shared multiplier result
  logic signed [31:0]  cmd_q;
  logic signed [31:0]  nv_q;
  logic signed [31:0]  new_velocity_q;
  logic [30:0]         remaining_q;

  // ---------------------------------------------------------------------------
  // datapath terms
  // ---------------------------------------------------------------------------
  logic signed [32:0] dp_w, dv_w;
  logic [32:0]        adp_w, adv_w;
  assign dp_w  = {tp_q[31], tp_q} - {cp_q[31], cp_q};
  assign dv_w  = {tv_q[31], tv_q} - {vel_q[31], vel_q};
  assign adp_w = dp_w[32] ? (~dp_w + 33'd1) : dp_w;
  assign adv_w = dv_w[32] ? (~dv_w + 33'd1) : dv_w;

  // distance beyond dead zone, saturated to 31 bits
  logic [32:0] beyond_w;
  logic [30:0] rem_w;
  assign beyond_w = adp_q - {2'b00, dead_distance_q};
  always_comb begin
    if (adp_q > {2'b00, dead_distance_q}) begin
      rem_w = (beyond_w[32:31] != 2'b00) ? U31Max : beyond_w[30:0];
    end else begin
      rem_w = '0;
    end
  end

  // one restoring divider step
  logic [DivDenW:0]   trial_w;
  logic               trial_ge_w;
  logic [DivDenW:0]   trial_sub_w;
  assign trial_w     = {rmd_q, num_q[DivNumW-1]};
  assign trial_ge_w  = (trial_w >= {1'b0, dvsr_q});
  assign trial_sub_w = trial_w - {1'b0, dvsr_q};

  // shared multiplier operands
  logic [31:0] mul_a_w, mul_b_w;
  always_comb begin
    if (state_q == ST_MUL_STOP) begin
      mul_a_w = adv_q[32:1];
      mul_b_w = {1'b0, ttf_q} + {15'b0, dt_eff};
    end else begin
      mul_a_w = {1'b0, accel_eff};
      mul_b_w = {15'b0, dt_eff};
    end
  end

  // stopping distance, kept wide for the compare
  logic [47:0] stop_w;
  logic        stop_gt_w;
  logic [30:0] slack_w;
  assign stop_w    = prod_q[63:QShift];
  assign stop_gt_w = (stop_w > {17'b0, rem_q});
  assign slack_w   = rem_q - stop_w[30:0];

  // approach speed cap and signed command
  logic [30:0]        spd_w;
  logic signed [33:0] cmd_sum_w;
  assign spd_w = (quo_q > {18'b0, max_velocity_q}) ? max_velocity_q : quo_q[30:0];
  always_comb begin
    if (dp_pos_q) begin
      cmd_sum_w = {{2{tv_q[31]}}, tv_q} + {3'b000, spd_q};
    end else if (dp_neg_q) begin
      cmd_sum_w = {{2{tv_q[31]}}, tv_q} - {3'b000, spd_q};
    end else begin
      cmd_sum_w = {{2{tv_q[31]}}, tv_q};
    end
  end

  // acceleration window around the kept velocity
  logic [31:0]        limit_w;
  logic signed [33:0] lo_w, hi_w, cmd_x_w, nv_x_w;
  assign limit_w = prod_q[47:QShift];
  assign lo_w    = {{2{vel_q[31]}}, vel_q} - {2'b00, limit_w};
  assign hi_w    = {{2{vel_q[31]}}, vel_q} + {2'b00, limit_w};
  assign cmd_x_w = {{2{cmd_q[31]}}, cmd_q};
  always_comb begin
    if (cmd_x_w < lo_w) begin
      nv_x_w = lo_w;
    end else if (cmd_x_w > hi_w) begin
      nv_x_w = hi_w;
    end else begin
      nv_x_w = cmd_x_w;
    end
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  logic in_take_w, out_load_w, div_last_w;
  assign div_last_w = (cnt_q == DivCntW'(DivSteps - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_PREP;
      ST_PREP:     state_d = ST_REM;
      ST_REM:      state_d = ST_DIV;
      ST_DIV:      if (div_last_w) state_d = ST_DIV_END;
      ST_DIV_END:  state_d = (div_sel_q == DIV_TTF) ? ST_MUL_STOP : ST_CMD;
      ST_MUL_STOP: state_d = ST_CMP;
      ST_CMP:      state_d = stop_gt_w ? ST_MUL_LIM : ST_DIV;
      ST_CMD:      state_d = ST_MUL_LIM;
      ST_MUL_LIM:  state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_take_w  = in_ready_o && in_valid_i;
    out_load_w = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_sel_q   <= DIV_TTF;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      vel_q       <= '0;
    end else begin
      state_q <= state_d;
      // divider bookkeeping
      if (state_q == ST_REM) begin
        div_sel_q <= DIV_TTF;
        cnt_q     <= '0;
      end else if (state_q == ST_CMP) begin
        div_sel_q <= DIV_SPEED;
        cnt_q     <= '0;
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + DivCntW'(1);
      end
      if (state_q == ST_CLAMP) begin
        vel_q <= sat_s32(nv_x_w);
      end
      // output register, freed when the beat is taken
      if (out_load_w) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_take_w) begin
      tv_q <= target_velocity_i;
      cp_q <= current_position_i;
      tp_q <= target_position_i;
    end
    case (state_q)
      ST_PREP: begin
        adp_q    <= adp_w;
        dp_pos_q <= !dp_w[32] && (dp_w != '0);
        dp_neg_q <= dp_w[32];
        adv_q    <= adv_w;
      end
      ST_REM: begin
        rem_q  <= rem_w;
        // time to final velocity: (dv << 16) / accel
        num_q  <= {adv_q, {QShift{1'b0}}};
        dvsr_q <= accel_eff;
        quo_q  <= '0;
        rmd_q  <= '0;
      end
      ST_DIV: begin
        num_q <= {num_q[DivNumW-2:0], 1'b0};
        quo_q <= {quo_q[DivNumW-2:0], trial_ge_w};
        rmd_q <= trial_ge_w ? trial_sub_w[DivDenW-1:0] : trial_w[DivDenW-1:0];
      end
      ST_DIV_END: begin
        if (div_sel_q == DIV_TTF) begin
          ttf_q <= (quo_q[DivNumW-1:31] != '0) ? U31Max : quo_q[30:0];
        end else begin
          spd_q <= spd_w;
        end
      end
      ST_MUL_STOP, ST_MUL_LIM: begin
        prod_q <= mul_a_w * mul_b_w;
      end
      ST_CMP: begin
        // stop beyond reach: command the target velocity
        cmd_q  <= tv_q;
        // approach speed: (remaining - stop) << 16 / tick
        num_q  <= {2'b00, slack_w, {QShift{1'b0}}};
        dvsr_q <= {14'b0, dt_eff};
        quo_q  <= '0;
        rmd_q  <= '0;
      end
      ST_CMD: begin
        cmd_q <= sat_s32(cmd_sum_w);
      end
      ST_CLAMP: begin
        nv_q <= sat_s32(nv_x_w);
      end
      default: ;
    endcase
    if (out_load_w) begin
      new_velocity_q <= nv_q;
      remaining_q    <= rem_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign new_velocity_o       = new_velocity_q;
  assign remaining_distance_o = remaining_q;

endmodule

`default_nettype wire
